/* hdl/midi_track_event_writer_assert.svh */
// ----------------------------------------------------------------------------
// MIDI track event writer assertion macros
// Shared property wrappers for the concurrent checks of the track writer.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_WRITER_ASSERT_SVH
`define MIDI_TRACK_EVENT_WRITER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held low.
`define MTEW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is held low.
`define MTEW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* hdl/mtew_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI track event writer package
// Widths, codes, the byte burst type and the variable-length encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mtew_pkg;

    // Tick time width and payload length width.
    localparam int TIME_BITS   = 28;
    localparam int LEN_BITS    = 28;

    // Variable-length quantity sizes.
    localparam int VLQ_BYTES     = (LEN_BITS + 6) / 7;
    localparam int VLQ_CNT_BITS  = $clog2(VLQ_BYTES + 1);
    localparam int DELTA_GROUPS  = (TIME_BITS + 6) / 7;

    // Longest burst: delta, status, meta type, length (or two data bytes).
    localparam int MAX_BYTES = DELTA_GROUPS + 2 + VLQ_BYTES;
    localparam int CNT_BITS  = $clog2(MAX_BYTES + 1);
    localparam int IDX_BITS  = $clog2(MAX_BYTES);

    // Item kinds.
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_EVENT   = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // Status and meta codes.
    localparam logic [7:0] STATUS_SYSTEM     = 8'hF0;
    localparam logic [7:0] STATUS_META       = 8'hFF;
    localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

    // Status high nibbles of the channel message groups.
    localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
    localparam logic [3:0] NIB_POLY_PRESS = 4'hA;
    localparam logic [3:0] NIB_CONTROL    = 4'hB;
    localparam logic [3:0] NIB_PROGRAM    = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
    localparam logic [3:0] NIB_PITCH_BEND = 4'hE;
    localparam logic [3:0] NIB_SYSTEM     = 4'hF;

    typedef struct packed {
        logic [VLQ_BYTES-1:0][7:0] bytes;   // index 0 goes out first
        logic [VLQ_CNT_BITS-1:0]   count;
    } t_vlq;

    // All bytes caused by one item, plus the byte total before them.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_BITS-1:0]       count;
        logic [31:0]               base;
        logic                      done;
    } t_burst;

    // Variable-length quantity: 7-bit groups, most significant first,
    // continuation bit set on every byte but the last.
    function automatic t_vlq vlq_encode(input logic [LEN_BITS-1:0] v);
        t_vlq                     r;
        logic [VLQ_BYTES*7-1:0]   wide;
        int                       g;
        wide    = (VLQ_BYTES * 7)'(v);
        r.count = VLQ_CNT_BITS'(1);
        r.bytes = '0;
        for (int k = 1; k < VLQ_BYTES; k++) begin
            if ((wide >> (7 * k)) != '0) begin
                r.count = VLQ_CNT_BITS'(k + 1);
            end
        end
        for (int k = 0; k < VLQ_BYTES; k++) begin
            g = int'(r.count) - 1 - k;
            if (g >= 0) begin
                r.bytes[k] = {(g != 0), wide[7*g +: 7]};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/midi_track_event_writer.sv */
// ----------------------------------------------------------------------------
// MIDI track event writer
// Encodes time-sorted events and payload bytes into MIDI track body bytes.
// ----------------------------------------------------------------------------
// Usage: the host offers items on the input channel (i_valid / o_ready):
// start-of-track, event, or payload byte. Body bytes leave on the output
// channel (o_valid / i_ready), one byte per transaction, with the running
// body byte count, a flag on the last byte of each item, and a flag on the
// last byte of the end-of-track event.
// The bytes of an item pass through the burst register and then the output
// register. An item produces 1 to 10 bytes, which leave through the
// one-byte-per-cycle output register while the receiver takes them; an item
// that produces no bytes does not occupy the burst register. The next item is taken in the cycle
// that the last byte of the current one moves to the output register.
// Reset clears the track state, the byte count and the valid flags of both holding registers.
// When the receiver stalls, the output byte holds and the burst register
// fills; the input then stalls until the burst drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_track_event_writer_assert.svh"

module midi_track_event_writer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [1:0]     i_kind,
    input  wire logic [27:0]    i_event_time,
    input  wire logic [7:0]     i_status,
    input  wire logic [7:0]     i_data_first,
    input  wire logic [7:0]     i_data_second,
    input  wire logic [27:0]    i_payload_length,
    input  wire logic [7:0]     i_payload_byte,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [7:0]          o_out_byte,
    output logic [31:0]         o_body_count,
    output logic                o_last,
    output logic                o_track_done
);

    logic               w_fire;
    logic               w_load;
    logic               w_free;
    mtew_pkg::t_burst   w_burst;

    // An item is taken whenever the burst register can take its bytes.
    assign o_ready = w_free;
    assign w_fire  = i_valid && w_free;
    assign w_load  = w_fire && (w_burst.count != '0);

    mtew_encoder u_encoder (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_kind           (i_kind),
        .i_event_time     (i_event_time),
        .i_status         (i_status),
        .i_data_first     (i_data_first),
        .i_data_second    (i_data_second),
        .i_payload_length (i_payload_length),
        .i_payload_byte   (i_payload_byte),
        .o_burst          (w_burst)
    );

    mtew_drain u_drain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_burst      (w_burst),
        .o_free       (w_free),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_body_count (o_body_count),
        .o_last       (o_last),
        .o_track_done (o_track_done)
    );

    // The end-of-track mark only appears on the closing byte of an item.
    `MTEW_ASSERT_NOW(a_done_on_last, i_clk, i_rst_n, o_valid && o_track_done, o_last)

    // Bytes of one item follow back to back with a count that steps by one.
    `MTEW_ASSERT_NEXT(a_burst_contiguous, i_clk, i_rst_n, o_valid && i_ready && !o_last, o_valid && (o_body_count == $past(o_body_count) + 32'd1))

endmodule

`default_nettype wire

/* hdl/mtew_encoder.sv */
// ----------------------------------------------------------------------------
// MIDI track event writer encoder
// Holds the track state and turns one accepted item into a byte burst.
// ----------------------------------------------------------------------------
`default_nettype none

module mtew_encoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_fire,
    input  wire logic [1:0]                        i_kind,
    input  wire logic [27:0]                       i_event_time,
    input  wire logic [7:0]                        i_status,
    input  wire logic [7:0]                        i_data_first,
    input  wire logic [7:0]                        i_data_second,
    input  wire logic [27:0]                       i_payload_length,
    input  wire logic [7:0]                        i_payload_byte,
    output mtew_pkg::t_burst                       o_burst
);

    logic [mtew_pkg::TIME_BITS-1:0] r_prev,    n_prev;
    logic [7:0]                     r_running, n_running;
    logic [mtew_pkg::LEN_BITS-1:0]  r_left,    n_left;
    logic                           r_end_pend, n_end_pend;
    logic                           r_ended,   n_ended;
    logic [31:0]                    r_total,   n_total;

    logic [mtew_pkg::TIME_BITS-1:0] w_time;
    logic [mtew_pkg::TIME_BITS-1:0] w_delta;
    logic [mtew_pkg::LEN_BITS-1:0]  w_left_dec;
    mtew_pkg::t_vlq                 w_dvlq;
    mtew_pkg::t_vlq                 w_lvlq;

    // Delta time clamps to zero when time goes backwards.
    assign w_time     = i_event_time[mtew_pkg::TIME_BITS-1:0];
    assign w_delta    = (w_time >= r_prev) ? (w_time - r_prev) : '0;
    assign w_left_dec = r_left - mtew_pkg::LEN_BITS'(1);
    assign w_dvlq     = mtew_pkg::vlq_encode(mtew_pkg::LEN_BITS'(w_delta));
    assign w_lvlq     = mtew_pkg::vlq_encode(i_payload_length);

    // Build the byte burst and the next track state.
    always_comb begin
        logic [mtew_pkg::CNT_BITS-1:0]         n;
        logic [mtew_pkg::MAX_BYTES-1:0][7:0]   bytes;
        logic                                  done;
        n          = '0;
        bytes      = '0;
        done       = 1'b0;
        n_prev     = r_prev;
        n_running  = r_running;
        n_left     = r_left;
        n_end_pend = r_end_pend;
        n_ended    = r_ended;

        if (i_kind == mtew_pkg::KIND_START) begin
            n_prev     = '0;
            n_running  = '0;
            n_left     = '0;
            n_end_pend = 1'b0;
            n_ended    = 1'b0;
        end else if (!r_ended) begin
            if (i_kind == mtew_pkg::KIND_EVENT && r_left == '0) begin
                n_prev = w_time;
                for (int k = 0; k < mtew_pkg::VLQ_BYTES; k++) begin
                    if (k < int'(w_dvlq.count)) begin
                        bytes[n[mtew_pkg::IDX_BITS-1:0]] = w_dvlq.bytes[k];
                        n = n + mtew_pkg::CNT_BITS'(1);
                    end
                end
                // Running status drops a repeated channel status.
                if (i_status != r_running || i_status >= mtew_pkg::STATUS_SYSTEM) begin
                    bytes[n[mtew_pkg::IDX_BITS-1:0]] = i_status;
                    n = n + mtew_pkg::CNT_BITS'(1);
                end
                n_running = i_status;
                unique case (i_status[7:4])
                    mtew_pkg::NIB_NOTE_OFF, mtew_pkg::NIB_NOTE_ON,
                    mtew_pkg::NIB_POLY_PRESS, mtew_pkg::NIB_CONTROL,
                    mtew_pkg::NIB_PITCH_BEND: begin
                        bytes[n[mtew_pkg::IDX_BITS-1:0]] = i_data_first;
                        n = n + mtew_pkg::CNT_BITS'(1);
                        bytes[n[mtew_pkg::IDX_BITS-1:0]] = i_data_second;
                        n = n + mtew_pkg::CNT_BITS'(1);
                    end
                    mtew_pkg::NIB_PROGRAM, mtew_pkg::NIB_CHAN_PRESS: begin
                        bytes[n[mtew_pkg::IDX_BITS-1:0]] = i_data_first;
                        n = n + mtew_pkg::CNT_BITS'(1);
                    end
                    mtew_pkg::NIB_SYSTEM: begin
                        if (i_status == mtew_pkg::STATUS_META) begin
                            bytes[n[mtew_pkg::IDX_BITS-1:0]] = i_data_first;
                            n = n + mtew_pkg::CNT_BITS'(1);
                        end
                        for (int k = 0; k < mtew_pkg::VLQ_BYTES; k++) begin
                            if (k < int'(w_lvlq.count)) begin
                                bytes[n[mtew_pkg::IDX_BITS-1:0]] = w_lvlq.bytes[k];
                                n = n + mtew_pkg::CNT_BITS'(1);
                            end
                        end
                        n_left = i_payload_length;
                        // End of track closes now or after its payload.
                        if (i_status == mtew_pkg::STATUS_META &&
                            i_data_first == mtew_pkg::META_END_OF_TRACK) begin
                            if (i_payload_length == '0) begin
                                done    = 1'b1;
                                n_ended = 1'b1;
                            end else begin
                                n_end_pend = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (i_kind == mtew_pkg::KIND_PAYLOAD && r_left != '0) begin
                bytes[0] = i_payload_byte;
                n        = mtew_pkg::CNT_BITS'(1);
                n_left   = w_left_dec;
                if (w_left_dec == '0 && r_end_pend) begin
                    n_end_pend = 1'b0;
                    n_ended    = 1'b1;
                    done       = 1'b1;
                end
            end
        end

        o_burst.bytes = bytes;
        o_burst.count = n;
        o_burst.base  = r_total;
        o_burst.done  = done;
        n_total = (i_kind == mtew_pkg::KIND_START) ? 32'd0 : (r_total + 32'(n));
    end

    // Track state registers, updated once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_running  <= '0;
            r_left     <= '0;
            r_end_pend <= 1'b0;
            r_ended    <= 1'b0;
            r_total    <= '0;
        end else if (i_fire) begin
            r_prev     <= n_prev;
            r_running  <= n_running;
            r_left     <= n_left;
            r_end_pend <= n_end_pend;
            r_ended    <= n_ended;
            r_total    <= n_total;
        end
    end

endmodule

`default_nettype wire

/* hdl/mtew_drain.sv */
// ----------------------------------------------------------------------------
// MIDI track event writer drain
// Holds one byte burst and moves it into the output register byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mtew_drain (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire mtew_pkg::t_burst   i_burst,
    output logic                    o_free,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_out_byte,
    output logic [31:0]             o_body_count,
    output logic                    o_last,
    output logic                    o_track_done
);

    mtew_pkg::t_burst                r_burst;
    logic                            r_a_valid;
    logic [mtew_pkg::IDX_BITS-1:0]   r_idx;
    logic                            r_b_valid;
    logic [7:0]                      r_byte;
    logic [31:0]                     r_count;
    logic                            r_last;
    logic                            r_done;

    logic                            w_move;
    logic                            w_a_last;
    logic [mtew_pkg::CNT_BITS-1:0]   w_idx_next;

    // A byte moves out when the output register is empty or being taken.
    assign w_move     = r_a_valid && (!r_b_valid || i_ready);
    assign w_idx_next = mtew_pkg::CNT_BITS'(r_idx) + mtew_pkg::CNT_BITS'(1);
    assign w_a_last   = (w_idx_next == r_burst.count);
    assign o_free     = !r_a_valid || (w_move && w_a_last);

    // Burst holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_idx     <= '0;
        end else if (i_load) begin
            r_a_valid <= 1'b1;
            r_idx     <= '0;
        end else if (w_move) begin
            r_a_valid <= !w_a_last;
            r_idx     <= w_a_last ? '0 : w_idx_next[mtew_pkg::IDX_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_move) begin
            r_b_valid <= 1'b1;
        end else if (i_ready) begin
            r_b_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_byte  <= r_burst.bytes[r_idx];
            r_count <= r_burst.base + 32'(w_idx_next);
            r_last  <= w_a_last;
            r_done  <= w_a_last && r_burst.done;
        end
    end

    assign o_valid      = r_b_valid;
    assign o_out_byte   = r_byte;
    assign o_body_count = r_count;
    assign o_last       = r_last;
    assign o_track_done = r_done;

endmodule

`default_nettype wire

/* bench/midi_track_event_writer_test.sv */
// ----------------------------------------------------------------------------
// MIDI track event writer testbench
// Drives start, event and payload transactions into the track writer and
// checks every body byte, its running count and its flags against a
// behavioral encoder or hand-typed bytes. A directed table covers the
// corner cases first. Random tracks with random idling on both sides follow.
// ----------------------------------------------------------------------------
module midi_track_event_writer_test;

    // Unused item kind, ignored by the writer.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [27:0] TICK_MAX     = 28'hFFFFFFF;
    localparam int          NO_TYPED     = -1;
    localparam int          MAX_REPORTS  = 10;
    localparam int          ITEM_TARGET  = 260;
    localparam int          LONG_STALL   = 200;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          LIMIT_CYCLES = 1_000_000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [27:0] tick;
        logic [7:0]  status;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [27:0] length;
        logic [7:0]  payload;
    } t_track_item;

    // Bytes typed in by hand, right-aligned, first byte most significant.
    typedef struct {
        int          n;
        logic [79:0] bytes;
    } t_typed_bytes;

    typedef struct {
        t_track_item  item;
        t_typed_bytes typed;
    } t_directed_row;

    typedef struct packed {
        logic [7:0]  value;
        logic [31:0] count;
        logic        last;
        logic        done;
    } t_body_byte;

    // Block ports.
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic [1:0]  i_kind           = mtew_pkg::KIND_START;
    logic [27:0] i_event_time     = '0;
    logic [7:0]  i_status         = '0;
    logic [7:0]  i_data_first     = '0;
    logic [7:0]  i_data_second    = '0;
    logic [27:0] i_payload_length = '0;
    logic [7:0]  i_payload_byte   = '0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic [7:0]  o_out_byte;
    logic [31:0] o_body_count;
    logic        o_last;
    logic        o_track_done;

    midi_track_event_writer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_event_time     (i_event_time),
        .i_status         (i_status),
        .i_data_first     (i_data_first),
        .i_data_second    (i_data_second),
        .i_payload_length (i_payload_length),
        .i_payload_byte   (i_payload_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_body_count     (o_body_count),
        .o_last           (o_last),
        .o_track_done     (o_track_done)
    );

    // Encoder state.
    logic [27:0] last_tick;
    logic [7:0]  run_status;
    logic [27:0] payload_owed;
    logic        end_owed;
    logic        track_over;
    logic [31:0] body_total;

    // Bytes caused by the item being encoded.
    logic [7:0]  burst_bytes [0:9];
    int          burst_len;
    logic        burst_done;
    logic [31:0] total_before;

    t_body_byte    body_bytes_due [$];
    t_typed_bytes  typed_due [$];
    t_directed_row directed_rows [$];

    int  errors          = 0;
    int  items_taken     = 0;
    bit  sender_idles    = 1'b1;
    bit  stall_req       = 1'b0;

    t_typed_bytes cur_typed;
    t_body_byte   want;
    t_body_byte   seen_due;
    int           n_due;

    // Clock.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #(12 * LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Behavioral encoder
    // ------------------------------------------------------------------------

    task automatic push_body_byte(input logic [7:0] b);
        body_total = body_total + 32'd1;
        burst_bytes[burst_len] = b;
        burst_len++;
    endtask

    // Variable-length quantity, most significant 7-bit group first.
    task automatic push_vlq(input logic [27:0] v);
        int groups;
        groups = 1;
        for (int g = 1; g < 4; g++) begin
            if ((v >> (7 * g)) != '0) begin
                groups = g + 1;
            end
        end
        for (int g = groups - 1; g >= 0; g--) begin
            push_body_byte({(g != 0), 7'(v >> (7 * g))});
        end
    endtask

    task automatic clear_track_state();
        last_tick    = '0;
        run_status   = '0;
        payload_owed = '0;
        end_owed     = 1'b0;
        track_over   = 1'b0;
        body_total   = '0;
    endtask

    task automatic encode_track_item(input t_track_item it);
        logic [27:0] delta;
        logic        is_end;
        burst_len    = 0;
        burst_done   = 1'b0;
        total_before = body_total;
        if (it.kind == mtew_pkg::KIND_START) begin
            clear_track_state();
            total_before = body_total;
        end else if (!track_over) begin
            case (it.kind)
                mtew_pkg::KIND_EVENT: begin
                    // Events are dropped while payload bytes are still owed.
                    if (payload_owed == '0) begin
                        delta = (it.tick >= last_tick) ? it.tick - last_tick : '0;
                        last_tick = it.tick;
                        push_vlq(delta);
                        if (it.status != run_status ||
                            it.status >= mtew_pkg::STATUS_SYSTEM) begin
                            push_body_byte(it.status);
                        end
                        run_status = it.status;
                        case (it.status[7:4])
                            mtew_pkg::NIB_NOTE_OFF, mtew_pkg::NIB_NOTE_ON,
                            mtew_pkg::NIB_POLY_PRESS, mtew_pkg::NIB_CONTROL,
                            mtew_pkg::NIB_PITCH_BEND: begin
                                push_body_byte(it.data_first);
                                push_body_byte(it.data_second);
                            end
                            mtew_pkg::NIB_PROGRAM, mtew_pkg::NIB_CHAN_PRESS: begin
                                push_body_byte(it.data_first);
                            end
                            mtew_pkg::NIB_SYSTEM: begin
                                is_end = 1'b0;
                                if (it.status == mtew_pkg::STATUS_META) begin
                                    is_end = (it.data_first == mtew_pkg::META_END_OF_TRACK);
                                    push_body_byte(it.data_first);
                                end
                                push_vlq(it.length);
                                payload_owed = it.length;
                                if (is_end) begin
                                    if (it.length == '0) begin
                                        burst_done = 1'b1;
                                        track_over = 1'b1;
                                    end else begin
                                        end_owed = 1'b1;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                mtew_pkg::KIND_PAYLOAD: begin
                    if (payload_owed != '0) begin
                        push_body_byte(it.payload);
                        payload_owed = payload_owed - 28'd1;
                        if (payload_owed == '0 && end_owed) begin
                            end_owed   = 1'b0;
                            track_over = 1'b1;
                            burst_done = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitors
    // ------------------------------------------------------------------------

    // Input transactions: encode and queue the expected body bytes.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            cur_typed = typed_due.pop_front();
            encode_track_item('{i_kind, i_event_time, i_status, i_data_first,
                                i_data_second, i_payload_length, i_payload_byte});
            n_due = (cur_typed.n == NO_TYPED) ? burst_len : cur_typed.n;
            for (int i = 0; i < n_due; i++) begin
                want.value = (cur_typed.n == NO_TYPED) ? burst_bytes[i]
                                                       : cur_typed.bytes[8*(n_due-1-i) +: 8];
                want.count = total_before + 32'(i + 1);
                want.last  = (i == n_due - 1);
                want.done  = (i == n_due - 1) && burst_done;
                body_bytes_due.push_back(want);
            end
            items_taken++;
        end
    end

    // Output transactions: compare with the oldest expected byte.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (body_bytes_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected byte %02h count %0d last %b done %b",
                             o_out_byte, o_body_count, o_last, o_track_done);
                end
            end else begin
                seen_due = body_bytes_due.pop_front();
                if (o_out_byte !== seen_due.value || o_body_count !== seen_due.count ||
                    o_last !== seen_due.last || o_track_done !== seen_due.done) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: expected %02h/%0d/%b/%b got %02h/%0d/%b/%b",
                                 seen_due.value, seen_due.count, seen_due.last,
                                 seen_due.done, o_out_byte, o_body_count, o_last,
                                 o_track_done);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request.
    // ------------------------------------------------------------------------
    initial begin
        int r;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (stall_req) begin
                i_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                stall_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    i_ready <= 1'b1;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end else if (r < 85) begin
                    i_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else if (r < 95) begin
                    i_ready <= 1'b0;
                    repeat ($urandom_range(4, 25)) @(posedge i_clk);
                end else begin
                    i_ready <= 1'b1;
                    repeat ($urandom_range(60, 300)) @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_idles || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one transaction and hold it until it is taken.
    task automatic send_item(input t_track_item it, input t_typed_bytes typed);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        typed_due.push_back(typed);
        i_valid          <= 1'b1;
        i_kind           <= it.kind;
        i_event_time     <= it.tick;
        i_status         <= it.status;
        i_data_first     <= it.data_first;
        i_data_second    <= it.data_second;
        i_payload_length <= it.length;
        i_payload_byte   <= it.payload;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic offer(input t_track_item it);
        send_item(it, '{NO_TYPED, '0});
    endtask

    // Stop offering until every expected byte has come out.
    task automatic drain_input();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (body_bytes_due.size() != 0);
    endtask

    function automatic t_track_item rand_item(input logic [1:0] kind);
        t_track_item it;
        it.kind        = kind;
        it.tick        = 28'($urandom);
        it.status      = 8'($urandom);
        it.data_first  = 8'($urandom);
        it.data_second = 8'($urandom);
        it.length      = 28'($urandom);
        it.payload     = 8'($urandom);
        return it;
    endfunction

    function automatic logic [27:0] next_tick(input logic [27:0] now);
        int unsigned step;
        int unsigned room;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            step = $urandom_range(0, 127);
        end else if (r < 80) begin
            step = $urandom_range(128, 16383);
        end else if (r < 95) begin
            step = $urandom_range(16384, 2097151);
        end else begin
            step = $urandom & 32'h0FFFFFFF;
        end
        room = 32'(TICK_MAX) - 32'(now);
        if (step > room) begin
            step = room;
        end
        return 28'(32'(now) + step);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return $urandom_range(0, 3);
        end else if (r < 90) begin
            return $urandom_range(4, 10);
        end else if (r < 97) begin
            return $urandom_range(11, 20);
        end
        return $urandom_range(120, 140);
    endfunction

    // One random track: mostly well-formed events with random content,
    // with some broken sequences and noise mixed in.
    task automatic gen_track();
        t_track_item it;
        logic [27:0] now;
        logic [7:0]  chan_status;
        int          r;
        int          plen;
        now          = '0;
        chan_status  = {mtew_pkg::NIB_NOTE_ON, 4'h0};
        sender_idles = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 14) == 0) begin
            stall_req = 1'b1;
        end
        if ($urandom_range(0, 9) != 0) begin
            offer(rand_item(mtew_pkg::KIND_START));
        end
        repeat ($urandom_range(1, 12)) begin
            now = next_tick(now);
            r   = $urandom_range(0, 99);
            it  = rand_item(mtew_pkg::KIND_EVENT);
            it.tick = now;
            if (r < 58) begin
                // Channel message; half the time the status repeats.
                if ($urandom_range(0, 1) == 0) begin
                    chan_status = {4'($urandom_range(8, 14)), 4'($urandom)};
                end
                it.status = chan_status;
                offer(it);
            end else if (r < 80) begin
                // System exclusive or meta event followed by its payload.
                plen = pick_length();
                if (r < 68) begin
                    it.status = mtew_pkg::STATUS_SYSTEM + 8'($urandom_range(0, 14));
                end else begin
                    it.status     = mtew_pkg::STATUS_META;
                    it.data_first = 8'($urandom_range(0, 127));
                    if (it.data_first == mtew_pkg::META_END_OF_TRACK) begin
                        it.data_first = 8'h01;
                    end
                end
                it.length = 28'(plen);
                offer(it);
                if (plen > 0 && $urandom_range(0, 7) == 0) begin
                    offer(rand_item(mtew_pkg::KIND_EVENT));
                end
                repeat (plen) offer(rand_item(mtew_pkg::KIND_PAYLOAD));
            end else if (r < 87) begin
                // Status without the top bit.
                it.status = 8'($urandom_range(0, 127));
                offer(it);
            end else if (r < 93) begin
                // Time goes backwards.
                now       = 28'($urandom_range(0, 32'(now)));
                it.tick   = now;
                it.status = chan_status;
                offer(it);
            end else begin
                case ($urandom_range(0, 2))
                    0: offer(rand_item(KIND_UNUSED));
                    1: offer(rand_item(mtew_pkg::KIND_PAYLOAD));
                    default: begin
                        offer(rand_item(mtew_pkg::KIND_EVENT));
                        repeat ($urandom_range(0, 3)) begin
                            offer(rand_item(mtew_pkg::KIND_PAYLOAD));
                        end
                    end
                endcase
            end
        end
        // Most tracks close with an end-of-track meta event.
        if ($urandom_range(0, 9) < 7) begin
            plen          = $urandom_range(0, 2);
            it            = rand_item(mtew_pkg::KIND_EVENT);
            it.tick       = next_tick(now);
            it.status     = mtew_pkg::STATUS_META;
            it.data_first = mtew_pkg::META_END_OF_TRACK;
            it.length     = 28'(plen);
            offer(it);
            repeat (plen) offer(rand_item(mtew_pkg::KIND_PAYLOAD));
            if ($urandom_range(0, 3) == 0) begin
                offer(rand_item(2'($urandom_range(1, 3))));
            end
        end
        if ($urandom_range(0, 7) == 0) begin
            drain_input();
        end
    endtask

    task automatic add_row(input logic [1:0] kind, input logic [27:0] tick,
                           input logic [7:0] status, input logic [7:0] d0,
                           input logic [7:0] d1, input logic [27:0] length,
                           input logic [7:0] payload, input int n,
                           input logic [79:0] bytes);
        t_directed_row row;
        row.item  = '{kind, tick, status, d0, d1, length, payload};
        row.typed = '{n, bytes};
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        clear_track_state();

        // Directed table. Rows with a byte count of NO_TYPED are predicted.
        add_row(mtew_pkg::KIND_EVENT, 28'h0, 8'h90, 8'h3C, 8'h7F, 28'h0, 8'h00, 4,
                80'h00903C7F);
        // Same status again: running status drops it.
        add_row(mtew_pkg::KIND_EVENT, 28'h0, 8'h90, 8'h40, 8'h00, 28'h0, 8'h00, 3,
                80'h004000);
        // Largest delta time.
        add_row(mtew_pkg::KIND_EVENT, TICK_MAX, 8'h80, 8'h7F, 8'h7F, 28'h0, 8'h00, 7,
                80'hFFFFFF7F807F7F);
        // Time goes backwards: delta is zero.
        add_row(mtew_pkg::KIND_EVENT, 28'h5, 8'hA0, 8'h01, 8'h02, 28'h0, 8'h00, 4,
                80'h00A00102);
        add_row(mtew_pkg::KIND_EVENT, 28'h85, 8'hB3, 8'h07, 8'h64, 28'h0, 8'h00,
                NO_TYPED, '0);
        add_row(mtew_pkg::KIND_EVENT, 28'h85, 8'hC5, 8'h11, 8'hEE, 28'h0, 8'h00,
                NO_TYPED, '0);
        add_row(mtew_pkg::KIND_EVENT, 28'h90, 8'hD0, 8'h55, 8'hAA, 28'h0, 8'h00,
                NO_TYPED, '0);
        add_row(mtew_pkg::KIND_EVENT, 28'h90, 8'hE0, 8'h00, 8'h40, 28'h0, 8'h00,
                NO_TYPED, '0);
        // Status without the top bit: no data bytes, and running status applies.
        add_row(mtew_pkg::KIND_EVENT, 28'h90, 8'h45, 8'h12, 8'h34, 28'h0, 8'h00, 2,
                80'h0045);
        add_row(mtew_pkg::KIND_EVENT, 28'h90, 8'h45, 8'h12, 8'h34, 28'h0, 8'h00, 1,
                80'h00);
        add_row(mtew_pkg::KIND_EVENT, 28'h91, mtew_pkg::STATUS_SYSTEM, 8'h00, 8'h00,
                28'h3, 8'h00, NO_TYPED, '0);
        // Event while payload is owed is dropped.
        add_row(mtew_pkg::KIND_EVENT, 28'h92, 8'h90, 8'h3C, 8'h40, 28'h0, 8'h00, 0, '0);
        add_row(mtew_pkg::KIND_PAYLOAD, 28'h0, 8'h00, 8'h00, 8'h00, 28'h0, 8'h00,
                NO_TYPED, '0);
        add_row(mtew_pkg::KIND_PAYLOAD, 28'h0, 8'h00, 8'h00, 8'h00, 28'h0, 8'hFF,
                NO_TYPED, '0);
        add_row(mtew_pkg::KIND_PAYLOAD, 28'h0, 8'h00, 8'h00, 8'h00, 28'h0, 8'hF7,
                NO_TYPED, '0);
        // Payload byte that is not owed, then the unused kind.
        add_row(mtew_pkg::KIND_PAYLOAD, 28'h0, 8'h00, 8'h00, 8'h00, 28'h0, 8'h55, 0, '0);
        add_row(KIND_UNUSED, TICK_MAX, 8'hFF, 8'hFF, 8'hFF, 28'hFFFFFFF, 8'hFF, 0, '0);
        // System status is written even when it repeats.
        add_row(mtew_pkg::KIND_EVENT, 28'h91, mtew_pkg::STATUS_SYSTEM, 8'h00, 8'h00,
                28'h0, 8'h00, 3, {8'h00, mtew_pkg::STATUS_SYSTEM, 8'h00});
        // Largest payload length; the start below clears what is owed.
        add_row(mtew_pkg::KIND_EVENT, 28'h91, mtew_pkg::STATUS_META, 8'h01, 8'h00,
                28'hFFFFFFF, 8'h00, 7,
                {8'h00, mtew_pkg::STATUS_META, 8'h01, 32'hFFFFFF7F});
        add_row(mtew_pkg::KIND_PAYLOAD, 28'h0, 8'h00, 8'h00, 8'h00, 28'h0, 8'h5A,
                NO_TYPED, '0);
        add_row(mtew_pkg::KIND_START, TICK_MAX, 8'hFF, 8'hFF, 8'hFF, 28'hFFFFFFF, 8'hFF,
                0, '0);
        // Status zero equals the cleared running status.
        add_row(mtew_pkg::KIND_EVENT, 28'h0, 8'h00, 8'h00, 8'h00, 28'h0, 8'h00, 1, 80'h00);
        // End of track with payload: done comes on its last payload byte.
        add_row(mtew_pkg::KIND_EVENT, 28'h3FFF, mtew_pkg::STATUS_META,
                mtew_pkg::META_END_OF_TRACK, 8'h00, 28'h1, 8'h00, NO_TYPED, '0);
        add_row(mtew_pkg::KIND_PAYLOAD, 28'h0, 8'h00, 8'h00, 8'h00, 28'h0, 8'h3C,
                NO_TYPED, '0);
        add_row(mtew_pkg::KIND_START, 28'h0, 8'h00, 8'h00, 8'h00, 28'h0, 8'h00, 0, '0);
        add_row(mtew_pkg::KIND_EVENT, 28'h0, mtew_pkg::STATUS_META,
                mtew_pkg::META_END_OF_TRACK, 8'h00, 28'h0, 8'h00, 4,
                {8'h00, mtew_pkg::STATUS_META, mtew_pkg::META_END_OF_TRACK, 8'h00});
        // Items after the end of track are dropped.
        add_row(mtew_pkg::KIND_PAYLOAD, 28'h0, 8'h00, 8'h00, 8'h00, 28'h0, 8'h77, 0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].typed);
        end
        drain_input();

        // Random tracks, opening with a long receiver hold-off.
        stall_req = 1'b1;
        while (items_taken < ITEM_TARGET) begin
            gen_track();
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (body_bytes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* midi_track_event_writer.f */
+incdir+hdl
hdl/mtew_pkg.sv
hdl/mtew_encoder.sv
hdl/mtew_drain.sv
hdl/midi_track_event_writer.sv
bench/midi_track_event_writer_test.sv
